// ----- hdl/sorted_timer_queue_assert.svh -----
// Assertion helpers for the sorted timer queue.
`ifndef SORTED_TIMER_QUEUE_ASSERT_SVH
`define SORTED_TIMER_QUEUE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define TSQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define TSQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/tsq_pkg.sv -----
`timescale 1ns / 1ps
package tsq_pkg;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_ADD    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_QUERY  = 2'd3
  } tsq_op_t;

  typedef enum logic [1:0] {
    KIND_ADD    = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_QUERY  = 2'd2,
    KIND_EXPIRY = 2'd3
  } tsq_kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_INS,
    ST_RESP,
    ST_TRD,
    ST_TEMIT
  } tsq_state_t;

  typedef struct packed {
    logic [15:0] id;
    logic [31:0] rem;
    logic [31:0] per;
    logic        rel;
    logic [31:0] handle;
  } tsq_entry_t;

  // At most this many expired entries are stashed and reported on one tick.
  localparam int MAX_FIRE = 16;
  localparam int FIRE_W   = 5;
  localparam int STASH_AW = 4;

endpackage

// ----- hdl/tsq_in_if.sv -----
`timescale 1ns / 1ps
interface tsq_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [15:0] tmr_id;
  logic [31:0] delay_ticks;
  logic        periodic;
  logic [31:0] tag;

  modport source (output valid, op, tmr_id, delay_ticks, periodic, tag, input ready);
  modport sink   (input valid, op, tmr_id, delay_ticks, periodic, tag, output ready);
endinterface

// ----- hdl/tsq_out_if.sv -----
`timescale 1ns / 1ps
interface tsq_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic        ok;
  logic [15:0] fired_id;
  logic [31:0] fired_tag;
  logic        last;

  modport source (output valid, kind, ok, fired_id, fired_tag, last, input ready);
  modport sink   (input valid, kind, ok, fired_id, fired_tag, last, output ready);
endinterface

// ----- hdl/tsq_ram.sv -----
`timescale 1ns / 1ps
module tsq_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- hdl/sorted_timer_queue.sv -----
`timescale 1ns / 1ps
// Add: one slot shifted per cycle from the back, then the answer; a full table is
// refused without a walk. Remove and query: one slot per cycle, then the answer.
// Tick: a decrement and compaction pass, then per expiry an emit plus a reinsertion
// for periodic timers.
// One item in work at a time; output stalls hold only the emit states, not the walk.
// Synchronous active-low reset empties the queue; no clearing pass of the memories.
module sorted_timer_queue #(
  parameter int SLOTS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  tsq_in_if.sink    in_item,
  tsq_out_if.source out_item
);
  import tsq_pkg::*;

  localparam int CW = $clog2(SLOTS + 1);
  localparam int AW = $clog2(SLOTS);

  tsq_state_t        st_r, st_nxt;
  tsq_op_t           op_r, op_nxt;
  logic [15:0]       id_r, id_nxt;
  tsq_entry_t        ins_r, ins_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [CW-1:0]     rd_c_r, rd_c_nxt;
  logic              p_v_r, p_v_nxt;
  logic [CW-1:0]     p_k_r, p_k_nxt;
  logic [CW-1:0]     w_r, w_nxt;
  logic              hit_r, hit_nxt;
  logic              ok_r, ok_nxt;
  logic [FIRE_W-1:0] nf_r, nf_nxt;
  logic [FIRE_W-1:0] j_r, j_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [1:0]        out_kind_r, out_kind_nxt;
  logic              out_ok_r, out_ok_nxt;
  logic [15:0]       out_id_r, out_id_nxt;
  logic [31:0]       out_tag_r, out_tag_nxt;
  logic              out_last_r, out_last_nxt;

  logic                mem_we;
  logic [AW-1:0]       mem_waddr, mem_raddr;
  tsq_entry_t          mem_wdata, mem_rd;
  logic                stash_we;
  logic [STASH_AW-1:0] stash_waddr;
  tsq_entry_t          stash_wdata, stash_rd;

  logic          can_emit;
  logic          ins_done;
  logic [CW-1:0] pk_inc, rd_dec;
  logic [31:0]   dec_rem;
  logic [FIRE_W-1:0] j_inc;

  tsq_ram #(.DEPTH(SLOTS), .WIDTH($bits(tsq_entry_t))) u_slots (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rd)
  );

  tsq_ram #(.DEPTH(MAX_FIRE), .WIDTH($bits(tsq_entry_t))) u_stash (
    .clk   (clk),
    .we    (stash_we),
    .waddr (stash_waddr),
    .wdata (stash_wdata),
    .raddr (j_r[STASH_AW-1:0]),
    .rdata (stash_rd)
  );

  assign can_emit = !out_valid_r || out_item.ready;
  assign pk_inc   = p_k_r + CW'(1);
  assign rd_dec   = rd_c_r - CW'(1);
  assign dec_rem  = (mem_rd.rem == 32'd0) ? 32'd0 : mem_rd.rem - 32'd1;
  assign j_inc    = j_r + FIRE_W'(1);

  assign in_item.ready      = (st_r == ST_IDLE);
  assign out_item.valid     = out_valid_r;
  assign out_item.kind      = out_kind_r;
  assign out_item.ok        = out_ok_r;
  assign out_item.fired_id  = out_id_r;
  assign out_item.fired_tag = out_tag_r;
  assign out_item.last      = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      count_r     <= '0;
      p_v_r       <= 1'b0;
      nf_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      count_r     <= count_nxt;
      p_v_r       <= p_v_nxt;
      nf_r        <= nf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    id_r       <= id_nxt;
    ins_r      <= ins_nxt;
    rd_c_r     <= rd_c_nxt;
    p_k_r      <= p_k_nxt;
    w_r        <= w_nxt;
    hit_r      <= hit_nxt;
    ok_r       <= ok_nxt;
    j_r        <= j_nxt;
    out_kind_r <= out_kind_nxt;
    out_ok_r   <= out_ok_nxt;
    out_id_r   <= out_id_nxt;
    out_tag_r  <= out_tag_nxt;
    out_last_r <= out_last_nxt;
  end

  always_comb begin
    st_nxt        = st_r;
    op_nxt        = op_r;
    id_nxt        = id_r;
    ins_nxt       = ins_r;
    count_nxt     = count_r;
    rd_c_nxt      = rd_c_r;
    p_v_nxt       = p_v_r;
    p_k_nxt       = p_k_r;
    w_nxt         = w_r;
    hit_nxt       = hit_r;
    ok_nxt        = ok_r;
    nf_nxt        = nf_r;
    j_nxt         = j_r;
    out_valid_nxt = out_valid_r;
    out_kind_nxt  = out_kind_r;
    out_ok_nxt    = out_ok_r;
    out_id_nxt    = out_id_r;
    out_tag_nxt   = out_tag_r;
    out_last_nxt  = out_last_r;
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = mem_rd;
    mem_raddr     = '0;
    stash_we      = 1'b0;
    stash_waddr   = nf_r[STASH_AW-1:0];
    stash_wdata   = mem_rd;
    ins_done      = 1'b0;

    if (out_valid_r && out_item.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (st_r)
      ST_IDLE: begin
        if (in_item.valid) begin
          op_nxt  = tsq_op_t'(in_item.op);
          id_nxt  = in_item.tmr_id;
          ins_nxt = '{id: in_item.tmr_id, rem: in_item.delay_ticks,
                      per: in_item.delay_ticks, rel: in_item.periodic,
                      handle: in_item.tag};
          p_v_nxt = 1'b0;
          if (tsq_op_t'(in_item.op) == OP_ADD) begin
            if (count_r == CW'(SLOTS)) begin
              ok_nxt = 1'b0;
              st_nxt = ST_RESP;
            end else begin
              rd_c_nxt = count_r;
              st_nxt   = ST_INS;
            end
          end else begin
            rd_c_nxt = '0;
            w_nxt    = '0;
            hit_nxt  = 1'b0;
            nf_nxt   = '0;
            st_nxt   = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        if (p_v_r) begin
          case (op_r)
            OP_TICK: begin
              // Expired entries form a prefix; stash them, compact the rest.
              if (dec_rem == 32'd0 && w_r == '0 && nf_r < FIRE_W'(MAX_FIRE)) begin
                stash_we = 1'b1;
                nf_nxt   = nf_r + FIRE_W'(1);
              end else begin
                mem_we        = 1'b1;
                mem_waddr     = w_r[AW-1:0];
                mem_wdata.rem = dec_rem;
                w_nxt         = w_r + CW'(1);
              end
            end
            OP_REMOVE: begin
              if (mem_rd.id == id_r) begin
                hit_nxt = 1'b1;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = w_r[AW-1:0];
                w_nxt     = w_r + CW'(1);
              end
            end
            default: begin
              if (mem_rd.id == id_r) begin
                hit_nxt = 1'b1;
              end
            end
          endcase
        end
        if (rd_c_r < count_r) begin
          mem_raddr = rd_c_r[AW-1:0];
          p_k_nxt   = rd_c_r;
          rd_c_nxt  = rd_c_r + CW'(1);
          p_v_nxt   = 1'b1;
        end else begin
          p_v_nxt = 1'b0;
          if (!p_v_r) begin
            case (op_r)
              OP_TICK: begin
                count_nxt = w_r;
                j_nxt     = '0;
                st_nxt    = (nf_r == '0) ? ST_IDLE : ST_TRD;
              end
              OP_REMOVE: begin
                count_nxt = w_r;
                ok_nxt    = hit_r;
                st_nxt    = ST_RESP;
              end
              default: begin
                ok_nxt = hit_r;
                st_nxt = ST_RESP;
              end
            endcase
          end
        end
      end

      ST_INS: begin
        // Walk from the back, shifting later entries up one slot.
        if (p_v_r) begin
          mem_we    = 1'b1;
          mem_waddr = pk_inc[AW-1:0];
          if (mem_rd.rem > ins_r.rem) begin
            mem_wdata = mem_rd;
          end else begin
            mem_wdata = ins_r;
            ins_done  = 1'b1;
          end
        end
        if (!ins_done) begin
          if (rd_c_r != '0) begin
            mem_raddr = rd_dec[AW-1:0];
            p_k_nxt   = rd_dec;
            rd_c_nxt  = rd_dec;
            p_v_nxt   = 1'b1;
          end else begin
            p_v_nxt = 1'b0;
            if (!p_v_r) begin
              mem_we    = 1'b1;
              mem_waddr = '0;
              mem_wdata = ins_r;
              ins_done  = 1'b1;
            end
          end
        end
        if (ins_done) begin
          count_nxt = count_r + CW'(1);
          p_v_nxt   = 1'b0;
          if (op_r == OP_ADD) begin
            ok_nxt = 1'b1;
            st_nxt = ST_RESP;
          end else begin
            j_nxt  = j_inc;
            st_nxt = (j_inc == nf_r) ? ST_IDLE : ST_TRD;
          end
        end
      end

      ST_RESP: begin
        if (can_emit) begin
          out_valid_nxt = 1'b1;
          case (op_r)
            OP_ADD:    out_kind_nxt = KIND_ADD;
            OP_REMOVE: out_kind_nxt = KIND_REMOVE;
            default:   out_kind_nxt = KIND_QUERY;
          endcase
          out_ok_nxt   = ok_r;
          out_id_nxt   = id_r;
          out_tag_nxt  = '0;
          out_last_nxt = 1'b1;
          st_nxt       = ST_IDLE;
        end
      end

      ST_TRD: begin
        st_nxt = ST_TEMIT;
      end

      ST_TEMIT: begin
        if (can_emit) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_EXPIRY;
          out_ok_nxt    = 1'b1;
          out_id_nxt    = stash_rd.id;
          out_tag_nxt   = stash_rd.handle;
          out_last_nxt  = (j_inc == nf_r);
          if (stash_rd.rel) begin
            ins_nxt  = '{id: stash_rd.id, rem: stash_rd.per, per: stash_rd.per,
                         rel: 1'b1, handle: stash_rd.handle};
            rd_c_nxt = count_r;
            p_v_nxt  = 1'b0;
            st_nxt   = ST_INS;
          end else begin
            j_nxt  = j_inc;
            st_nxt = (j_inc == nf_r) ? ST_IDLE : ST_TRD;
          end
        end
      end

      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

`include "sorted_timer_queue_assert.svh"

  `TSQ_ASSERT_NOW(a_count_max, 1'b1, count_r <= CW'(SLOTS), "entry count above capacity")
  `TSQ_ASSERT_NOW(a_ins_room, st_r == ST_INS, count_r < CW'(SLOTS), "insert into a full table")
  `TSQ_ASSERT_NOW(a_fire_max, 1'b1, nf_r <= FIRE_W'(MAX_FIRE), "too many expiries on one tick")
  `TSQ_ASSERT_NOW(a_compact, st_r == ST_SCAN, w_r <= rd_c_r, "compaction write passed the read")
  `TSQ_ASSERT_NEXT(a_out_hold, out_valid_r && !out_item.ready, out_valid_r && $stable(out_id_r), "pending result dropped")

endmodule
